// File: hw/rtl/sti_pkg.sv
// -----------------------------------------------------------------------------
// sti_pkg
// Command, status and sequencer state codes of the sorted table.
// -----------------------------------------------------------------------------
package sti_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_ABSENT = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_INS_WALK,
      SQ_INS_PUT,
      SQ_FIND,
      SQ_SHIFT,
      SQ_RESP
   } seq_state_type;

   localparam int ValueW    = 32;
   localparam int PositionW = 6;
   localparam int TotalW    = 7;

endpackage

// File: hw/rtl/sti_req_if.sv
// -----------------------------------------------------------------------------
// sti_req_if
// Command channel: valid/ready handshake with command and value.
// -----------------------------------------------------------------------------
interface sti_req_if;

   logic                              valid;
   logic                              ready;
   sti_pkg::cmd_type                  command;
   logic signed [sti_pkg::ValueW-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);

endinterface

// File: hw/rtl/sti_rsp_if.sv
// -----------------------------------------------------------------------------
// sti_rsp_if
// Result channel: valid/ready handshake with status, found, position, total.
// -----------------------------------------------------------------------------
interface sti_rsp_if;

   logic                           valid;
   logic                           ready;
   sti_pkg::status_type            status;
   logic                           found;
   logic [sti_pkg::PositionW-1:0]  position;
   logic [sti_pkg::TotalW-1:0]     entry_total;

   modport source (output valid, output status, output found, output position,
                   output entry_total, input ready);
   modport sink   (input valid, input status, input found, input position,
                   input entry_total, output ready);

endinterface

// File: hw/rtl/sorted_table_insert_remove_search.sv
// -----------------------------------------------------------------------------
// sorted_table_insert_remove_search
// Holds up to DEPTH signed 32-bit values in ascending order (duplicates kept)
// in a single-port-write, single-port-read RAM. One command at a time: insert
// walks down from the top, moving each entry not smaller than the value up by
// one; remove walks up to the first equal entry and then closes the gap;
// search walks up to the first equal entry; clear just zeroes the count.
// The sequencer does one RAM step per cycle while it walks; clear and an
// insert into a full table go straight to the result step, which waits
// until the result channel can take the result.
// A new command is taken while the previous result still waits on the
// result channel. No clearing pass is needed after reset.
// -----------------------------------------------------------------------------
module sorted_table_insert_remove_search #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   sti_req_if.sink     req_if,
   sti_rsp_if.source   rsp_if
);

   localparam int IdxW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   sti_pkg::seq_state_type state_ff, state_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [CntW-1:0]  idx_ff, idx_in;
   sti_pkg::cmd_type cmd_ff, cmd_in;
   logic signed [sti_pkg::ValueW-1:0] val_ff, val_in;
   logic [IdxW-1:0]  pos_ff, pos_in;
   sti_pkg::status_type res_status_ff, res_status_in;
   logic             res_found_ff, res_found_in;

   logic             rsp_valid_ff, rsp_valid_in;
   sti_pkg::status_type rsp_status_ff, rsp_status_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [IdxW-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [CntW-1:0]  rsp_total_ff, rsp_total_in;

   logic                       wr_en;
   logic [IdxW-1:0]            wr_addr;
   logic [sti_pkg::ValueW-1:0] wr_data;
   logic [IdxW-1:0]            rd_addr;
   logic [sti_pkg::ValueW-1:0] rd_data;
   logic                       load_out;

   // Read and write addresses are two apart while walking; where they meet in
   // one cycle the read data goes unused, so no forwarding is needed.
   sti_ram #(.DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_if.ready = (state_ff == sti_pkg::SQ_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      wr_en         = 1'b0;
      wr_addr       = IdxW'(idx_ff);
      wr_data       = val_ff;
      rd_addr       = '0;
      load_out      = 1'b0;

      unique case (state_ff)
         sti_pkg::SQ_IDLE: begin
            if (req_if.valid) begin
               cmd_in        = req_if.command;
               val_in        = req_if.value;
               pos_in        = '0;
               res_found_in  = 1'b0;
               res_status_in = sti_pkg::ST_DONE;
               idx_in        = '0;
               unique case (req_if.command)
                  sti_pkg::CMD_INSERT: begin
                     if (count_ff == CntW'(DEPTH)) begin
                        res_status_in = sti_pkg::ST_FULL;
                        state_in      = sti_pkg::SQ_RESP;
                     end else if (count_ff == '0) begin
                        state_in = sti_pkg::SQ_INS_PUT;
                     end else begin
                        idx_in   = count_ff;
                        rd_addr  = IdxW'(count_ff - CntW'(1));
                        state_in = sti_pkg::SQ_INS_WALK;
                     end
                  end
                  sti_pkg::CMD_REMOVE, sti_pkg::CMD_SEARCH: begin
                     if (count_ff == '0) begin
                        res_status_in = sti_pkg::ST_ABSENT;
                        state_in      = sti_pkg::SQ_RESP;
                     end else begin
                        state_in = sti_pkg::SQ_FIND;
                     end
                  end
                  sti_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     state_in = sti_pkg::SQ_RESP;
                  end
                  default: state_in = sti_pkg::SQ_IDLE;
               endcase
            end
         end

         // rd_data holds entry idx-1
         sti_pkg::SQ_INS_WALK: begin
            if (!($signed(rd_data) < val_ff)) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               idx_in  = idx_ff - CntW'(1);
               if (idx_ff == CntW'(1)) begin
                  state_in = sti_pkg::SQ_INS_PUT;
               end else begin
                  rd_addr = IdxW'(idx_ff - CntW'(2));
               end
            end else begin
               state_in = sti_pkg::SQ_INS_PUT;
            end
         end

         sti_pkg::SQ_INS_PUT: begin
            wr_en    = 1'b1;
            wr_data  = val_ff;
            pos_in   = IdxW'(idx_ff);
            count_in = count_ff + CntW'(1);
            state_in = sti_pkg::SQ_RESP;
         end

         // rd_data holds entry idx
         sti_pkg::SQ_FIND: begin
            if ($signed(rd_data) == val_ff) begin
               pos_in       = IdxW'(idx_ff);
               res_found_in = 1'b1;
               if (cmd_ff == sti_pkg::CMD_SEARCH) begin
                  state_in = sti_pkg::SQ_RESP;
               end else if (idx_ff + CntW'(1) < count_ff) begin
                  rd_addr  = IdxW'(idx_ff + CntW'(1));
                  state_in = sti_pkg::SQ_SHIFT;
               end else begin
                  count_in = count_ff - CntW'(1);
                  state_in = sti_pkg::SQ_RESP;
               end
            end else if (idx_ff + CntW'(1) < count_ff) begin
               rd_addr = IdxW'(idx_ff + CntW'(1));
               idx_in  = idx_ff + CntW'(1);
            end else begin
               res_status_in = sti_pkg::ST_ABSENT;
               state_in      = sti_pkg::SQ_RESP;
            end
         end

         // rd_data holds entry idx+1, moved down into idx
         sti_pkg::SQ_SHIFT: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            if (idx_ff + CntW'(2) < count_ff) begin
               rd_addr = IdxW'(idx_ff + CntW'(2));
               idx_in  = idx_ff + CntW'(1);
            end else begin
               count_in = count_ff - CntW'(1);
               state_in = sti_pkg::SQ_RESP;
            end
         end

         sti_pkg::SQ_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               load_out = 1'b1;
               state_in = sti_pkg::SQ_IDLE;
            end
         end

         default: state_in = sti_pkg::SQ_IDLE;
      endcase
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_found_in  = res_found_ff;
         rsp_pos_in    = pos_ff;
         rsp_total_in  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sti_pkg::SQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.found       = rsp_found_ff;
   assign rsp_if.position    = sti_pkg::PositionW'(rsp_pos_ff);
   assign rsp_if.entry_total = sti_pkg::TotalW'(rsp_total_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("entry count beyond table depth");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> CntW'(wr_addr) <= count_ff)
      else $error("RAM write above the held entries");

   a_load_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == sti_pkg::SQ_RESP)
      else $error("result raised outside the result step");

   a_found_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_status_ff == sti_pkg::ST_DONE)
      else $error("found flag with a failing status");

endmodule

// File: hw/rtl/sti_ram.sv
// -----------------------------------------------------------------------------
// sti_ram
// Value store: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module sti_ram #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [sti_pkg::ValueW-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [sti_pkg::ValueW-1:0]        rd_data
);

   logic [sti_pkg::ValueW-1:0] mem [DEPTH];
   logic [sti_pkg::ValueW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/sorted_table_insert_remove_search_test.sv
// -----------------------------------------------------------------------------
// sorted_table_insert_remove_search_test
// Self-checking bench for the sorted table. A directed table covers an empty
// table, extreme values, duplicates, absent values and clear. Random traffic
// follows in fill, drain and mixed phases, so the table is filled and emptied
// many times. Results are checked against a local copy of the table, or
// against the row's own expectation for typed directed rows. Both channels
// idle at random, and the receiver once holds off for a long stretch.
// -----------------------------------------------------------------------------
module sorted_table_insert_remove_search_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TableDepth   = 64;
   localparam int HeldIdxW     = $clog2(TableDepth);
   localparam int RandomItems  = 1950;
   localparam int DirectedRows = 20;
   localparam int LongHold     = 400;
   localparam int DrainCycles  = 150;

   typedef struct packed {
      sti_pkg::status_type                 status;
      logic                                found;
      logic [sti_pkg::PositionW-1:0]       position;
      logic [sti_pkg::TotalW-1:0]          entry_total;
   } outcome_type;

   typedef struct {
      sti_pkg::cmd_type                  command;
      logic signed [sti_pkg::ValueW-1:0] value;
      bit                                typed;
      outcome_type                       want;
   } stim_row_type;

   typedef enum int {
      PH_FILL,
      PH_DRAIN,
      PH_MIX
   } load_phase_type;

   logic clock = 1'b0;
   logic reset;

   sti_req_if req ();
   sti_rsp_if rsp ();

   sorted_table_insert_remove_search #(
      .DEPTH (TableDepth)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // local copy of the table, updated on each accepted item
   logic signed [sti_pkg::ValueW-1:0] held_values [TableDepth];
   int                                held_count = 0;
   outcome_type                       pending_outcomes [$];
   int                                errors = 0;

   // set by the sender while an item with a typed expectation is on offer
   bit                       offer_typed = 1'b0;
   outcome_type              offer_want = '0;

   bit                       tx_calm = 1'b0;
   bit                       rx_calm = 1'b0;
   bit                       rx_long_hold = 1'b0;

   stim_row_type directed_rows [DirectedRows] = '{
      '{sti_pkg::CMD_SEARCH, 32'sd0,         1'b1, '{sti_pkg::ST_ABSENT, 1'b0, 6'd0, 7'd0}},
      '{sti_pkg::CMD_REMOVE, -32'sd1,        1'b1, '{sti_pkg::ST_ABSENT, 1'b0, 6'd0, 7'd0}},
      '{sti_pkg::CMD_INSERT, 32'sd0,         1'b1, '{sti_pkg::ST_DONE,   1'b0, 6'd0, 7'd1}},
      '{sti_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 1'b1, '{sti_pkg::ST_DONE,   1'b0, 6'd1, 7'd2}},
      '{sti_pkg::CMD_INSERT, 32'sh8000_0000, 1'b1, '{sti_pkg::ST_DONE,   1'b0, 6'd0, 7'd3}},
      '{sti_pkg::CMD_INSERT, -32'sd1,        1'b0, '0},
      '{sti_pkg::CMD_INSERT, 32'sd0,         1'b0, '0},
      '{sti_pkg::CMD_SEARCH, 32'sd0,         1'b0, '0},
      '{sti_pkg::CMD_SEARCH, 32'sh7FFF_FFFF, 1'b0, '0},
      '{sti_pkg::CMD_SEARCH, 32'sh8000_0000, 1'b0, '0},
      '{sti_pkg::CMD_SEARCH, 32'sd1,         1'b0, '0},
      '{sti_pkg::CMD_REMOVE, 32'sd0,         1'b0, '0},
      '{sti_pkg::CMD_REMOVE, 32'sh7FFF_FFFF, 1'b0, '0},
      '{sti_pkg::CMD_REMOVE, 32'sd12345,     1'b0, '0},
      '{sti_pkg::CMD_INSERT, 32'sh8000_0000, 1'b0, '0},
      '{sti_pkg::CMD_REMOVE, 32'sh8000_0000, 1'b0, '0},
      '{sti_pkg::CMD_CLEAR,  32'sh5555_AAAA, 1'b1, '{sti_pkg::ST_DONE,   1'b0, 6'd0, 7'd0}},
      '{sti_pkg::CMD_SEARCH, 32'sh8000_0000, 1'b1, '{sti_pkg::ST_ABSENT, 1'b0, 6'd0, 7'd0}},
      '{sti_pkg::CMD_REMOVE, 32'sd0,         1'b1, '{sti_pkg::ST_ABSENT, 1'b0, 6'd0, 7'd0}},
      '{sti_pkg::CMD_CLEAR,  -32'sd1,        1'b1, '{sti_pkg::ST_DONE,   1'b0, 6'd0, 7'd0}}
   };

   function automatic outcome_type apply_command(sti_pkg::cmd_type cmd,
                                                 logic signed [sti_pkg::ValueW-1:0] v);
      outcome_type o;
      int          at;
      int          i;
      o = '{status: sti_pkg::ST_DONE, found: 1'b0, position: '0, entry_total: '0};
      at = 0;
      case (cmd)
         sti_pkg::CMD_INSERT: begin
            if (held_count >= TableDepth) begin
               o.status = sti_pkg::ST_FULL;
            end else begin
               // new value goes ahead of its equals
               while (at < held_count && held_values[HeldIdxW'(at)] < v) at++;
               for (i = held_count; i > at; i--)
                  held_values[HeldIdxW'(i)] = held_values[HeldIdxW'(i - 1)];
               held_values[HeldIdxW'(at)] = v;
               held_count++;
               o.position = sti_pkg::PositionW'(at);
            end
         end
         sti_pkg::CMD_REMOVE, sti_pkg::CMD_SEARCH: begin
            while (at < held_count && held_values[HeldIdxW'(at)] != v) at++;
            if (at < held_count) begin
               o.found = 1'b1;
               o.position = sti_pkg::PositionW'(at);
               if (cmd == sti_pkg::CMD_REMOVE) begin
                  for (i = at; i + 1 < held_count; i++)
                     held_values[HeldIdxW'(i)] = held_values[HeldIdxW'(i + 1)];
                  held_count--;
               end
            end else begin
               o.status = sti_pkg::ST_ABSENT;
            end
         end
         default: begin
            held_count = 0;
         end
      endcase
      o.entry_total = sti_pkg::TotalW'(held_count);
      return o;
   endfunction

   function automatic logic signed [sti_pkg::ValueW-1:0] draw_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return int'($urandom_range(0, 15)) - 8;
      if (r < 55) begin
         case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh7FFF_FFFE;
            2: return 32'sh8000_0000;
            3: return 32'sh8000_0001;
            4: return -32'sd1;
            default: return 32'sd0;
         endcase
      end
      return $urandom;
   endfunction

   // removes and searches mostly aim at values that are held
   function automatic logic signed [sti_pkg::ValueW-1:0] draw_operand(sti_pkg::cmd_type cmd);
      if ((cmd == sti_pkg::CMD_REMOVE || cmd == sti_pkg::CMD_SEARCH) && held_count > 0 &&
          $urandom_range(0, 3) != 0)
         return held_values[HeldIdxW'($urandom_range(0, held_count - 1))];
      return draw_value();
   endfunction

   function automatic sti_pkg::cmd_type draw_command(load_phase_type phase);
      int r;
      r = $urandom_range(0, 99);
      case (phase)
         PH_FILL: begin
            if (r < 88) return sti_pkg::CMD_INSERT;
            if (r < 94) return sti_pkg::CMD_REMOVE;
            return sti_pkg::CMD_SEARCH;
         end
         PH_DRAIN: begin
            if (r < 2) return sti_pkg::CMD_CLEAR;
            if (r < 15) return sti_pkg::CMD_INSERT;
            if (r < 75) return sti_pkg::CMD_REMOVE;
            return sti_pkg::CMD_SEARCH;
         end
         default: begin
            if (r < 3) return sti_pkg::CMD_CLEAR;
            if (r < 40) return sti_pkg::CMD_INSERT;
            if (r < 70) return sti_pkg::CMD_REMOVE;
            return sti_pkg::CMD_SEARCH;
         end
      endcase
   endfunction

   // entered and left at a falling edge
   task automatic send_item(sti_pkg::cmd_type cmd, logic signed [sti_pkg::ValueW-1:0] v,
                            bit typed, outcome_type want);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 14);
      repeat (gap) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      offer_typed = typed;
      offer_want  = want;
      req.valid   <= 1'b1;
      req.command <= cmd;
      req.value   <= v;
      do @(posedge clock); while (req.ready !== 1'b1);
      @(negedge clock);
   endtask

   // prediction on acceptance, checking on each result
   always @(posedge clock) begin
      outcome_type predicted;
      outcome_type want;
      if (!reset) begin
         if (req.valid === 1'b1 && req.ready === 1'b1) begin
            predicted = apply_command(req.command, req.value);
            pending_outcomes.push_back(offer_typed ? offer_want : predicted);
         end
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
               $error("result item with nothing expected");
               errors++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp.status);
                  errors++;
               end
               if (rsp.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp.found);
                  errors++;
               end
               if (rsp.position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp.position);
                  errors++;
               end
               if (rsp.entry_total !== want.entry_total) begin
                  $error("entry_total: expected %0d, got %0d", want.entry_total,
                         rsp.entry_total);
                  errors++;
               end
            end
         end
      end
   end

   // result side: random stalls per item, one long hold-off on request
   initial begin
      int stall;
      rsp.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (rx_long_hold) begin
            rx_long_hold = 1'b0;
            stall = LongHold;
         end else begin
            stall = rx_calm ? 0 : $urandom_range(0, 14);
         end
         repeat (stall) begin
            rsp.ready <= 1'b0;
            @(negedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (rsp.valid !== 1'b1);
         @(negedge clock);
      end
   end

   initial begin
      load_phase_type   phase;
      int               phase_left;
      int               random_sent;
      sti_pkg::cmd_type cmd;
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.command = sti_pkg::CMD_INSERT;
      req.value   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[k])
         send_item(directed_rows[k].command, directed_rows[k].value,
                   directed_rows[k].typed, directed_rows[k].want);

      // first phase fills the table past full
      phase       = PH_FILL;
      phase_left  = 80;
      random_sent = 0;
      while (random_sent < RandomItems) begin
         if (phase_left == 0) begin
            phase      = load_phase_type'($urandom_range(0, 2));
            phase_left = $urandom_range(20, 90);
            tx_calm    = ($urandom_range(0, 3) == 0);
            rx_calm    = ($urandom_range(0, 3) == 0);
         end
         if (random_sent == 600) rx_long_hold = 1'b1;
         if (random_sent == 1200) begin
            req.valid <= 1'b0;
            wait (pending_outcomes.size() == 0);
            @(negedge clock);
         end
         cmd = draw_command(phase);
         send_item(cmd, draw_operand(cmd), 1'b0, '0);
         random_sent++;
         phase_left--;
      end
      req.valid <= 1'b0;

      wait (pending_outcomes.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0) begin
         $display("sorted_table_insert_remove_search_test OK");
      end else begin
         $display("sorted_table_insert_remove_search_test NOT OK");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("sorted_table_insert_remove_search_test NOT OK");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/sti_pkg.sv
hw/rtl/sti_req_if.sv
hw/rtl/sti_rsp_if.sv
hw/rtl/sti_ram.sv
hw/rtl/sorted_table_insert_remove_search.sv
tb/sorted_table_insert_remove_search_test.sv
